>>> rtl/core/lpkt_pkg.sv
// Shared types, constants and the sequencer program of the linear probe key table.
package lpkt_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned GRADE_W  = 10;
  localparam int unsigned ENTRY_W  = 1 + GRADE_W + KEY_W;

  localparam logic [GRADE_W-1:0] GRADE_MIN = GRADE_W'(200);
  localparam logic [GRADE_W-1:0] GRADE_MAX = GRADE_W'(600);
  localparam logic [GRADE_W-1:0] GRADE_BAD = GRADE_W'(100);

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_MISS = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef logic [2:0] step_t;

  localparam step_t STEP_CLEAR = 3'd0;
  localparam step_t STEP_IDLE  = 3'd1;
  localparam step_t STEP_QUOT  = 3'd2;
  localparam step_t STEP_PROD  = 3'd3;
  localparam step_t STEP_MOD   = 3'd4;
  localparam step_t STEP_READ  = 3'd5;
  localparam step_t STEP_EVAL  = 3'd6;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_ACCEPT,
    COND_CLR_LAST,
    COND_FINISH
  } cond_e;

  typedef struct packed {
    logic  in_ready;
    logic  clr_en;
    logic  quot_en;
    logic  prod_en;
    logic  mod_en;
    logic  eval_en;
    cond_e cond;
    step_t on_true;
    step_t on_false;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '{in_ready: 1'b0, clr_en: 1'b0, quot_en: 1'b0, prod_en: 1'b0, mod_en: 1'b0,
          eval_en: 1'b0, cond: COND_ALWAYS, on_true: STEP_IDLE, on_false: STEP_IDLE};
    unique case (step)
      STEP_CLEAR: begin
        w.clr_en   = 1'b1;
        w.cond     = COND_CLR_LAST;
        w.on_true  = STEP_IDLE;
        w.on_false = STEP_CLEAR;
      end
      STEP_IDLE: begin
        w.in_ready = 1'b1;
        w.cond     = COND_ACCEPT;
        w.on_true  = STEP_QUOT;
        w.on_false = STEP_IDLE;
      end
      STEP_QUOT: begin
        w.quot_en  = 1'b1;
        w.cond     = COND_ALWAYS;
        w.on_true  = STEP_PROD;
        w.on_false = STEP_PROD;
      end
      STEP_PROD: begin
        w.prod_en  = 1'b1;
        w.cond     = COND_ALWAYS;
        w.on_true  = STEP_MOD;
        w.on_false = STEP_MOD;
      end
      STEP_MOD: begin
        w.mod_en   = 1'b1;
        w.cond     = COND_ALWAYS;
        w.on_true  = STEP_READ;
        w.on_false = STEP_READ;
      end
      STEP_READ: begin
        w.cond     = COND_ALWAYS;
        w.on_true  = STEP_EVAL;
        w.on_false = STEP_EVAL;
      end
      STEP_EVAL: begin
        w.eval_en  = 1'b1;
        w.cond     = COND_FINISH;
        w.on_true  = STEP_IDLE;
        w.on_false = STEP_READ;
      end
      default: begin
        w.cond     = COND_ALWAYS;
        w.on_true  = STEP_IDLE;
        w.on_false = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/lpkt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lpkt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/linear_probe_key_table.sv
// Top level of the linear probe key table: sequencer, datapath and entry memory.
//
// Open-addressed table of TABLE_SLOTS entries keyed by a 32-bit number, with the home slot at
// key mod TABLE_SLOTS and upward probing that does not wrap. After reset the block clears the
// occupied marks of all slots and accepts no item until that pass ends. An item is then
// transferred in and finds its home slot by a multiplication by the reciprocal of TABLE_SLOTS,
// a multiplication back and one correcting subtraction. It then reads and evaluates each slot
// probed in turn (the entry memory has one registered read port). The result sits in an output
// register, so the next item is taken while it waits for its transfer out.
module linear_probe_key_table #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [lpkt_pkg::KEY_W-1:0]   key_i,
  input  logic [lpkt_pkg::GRADE_W-1:0] grade_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [3:0]                  slot_o,
  output logic [lpkt_pkg::GRADE_W-1:0] found_grade_o,
  output logic                        best_valid_o,
  output logic [lpkt_pkg::KEY_W-1:0]   best_key_o,
  output logic [lpkt_pkg::GRADE_W-1:0] best_grade_o
);

  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [lpkt_pkg::KEY_W-1:0] SLOTS_K = lpkt_pkg::KEY_W'(TABLE_SLOTS);
  localparam logic [lpkt_pkg::KEY_W-1:0] RECIP   =
    lpkt_pkg::KEY_W'(64'h1_0000_0000 / 64'(TABLE_SLOTS));

  lpkt_pkg::step_t step_q, step_d;
  lpkt_pkg::ctrl_t ctrl;

  logic [SLOT_W-1:0]               pos_q, pos_d;
  logic                            mode_q;
  logic [lpkt_pkg::KEY_W-1:0]      key_q;
  logic [lpkt_pkg::GRADE_W-1:0]    grade_q;

  logic [lpkt_pkg::KEY_W-1:0]      quot_q, quot_d;
  logic [lpkt_pkg::KEY_W-1:0]      prod_q, prod_d;

  logic                            any_q, any_d;
  logic [SLOT_W-1:0]               best_idx_q, best_idx_d;
  logic [lpkt_pkg::GRADE_W-1:0]    best_grade_q, best_grade_d;
  logic [lpkt_pkg::KEY_W-1:0]      best_key_q, best_key_d;

  logic                            out_valid_q, out_valid_d;
  logic [1:0]                      status_q;
  logic [3:0]                      slot_q;
  logic [lpkt_pkg::GRADE_W-1:0]    found_grade_q;
  logic                            best_valid_q;
  logic [lpkt_pkg::KEY_W-1:0]      best_key_out_q;
  logic [lpkt_pkg::GRADE_W-1:0]    best_grade_out_q;

  logic [lpkt_pkg::ENTRY_W-1:0]    rdata;
  logic [lpkt_pkg::ENTRY_W-1:0]    wdata;
  logic                            we;

  logic                            ent_used;
  logic [lpkt_pkg::GRADE_W-1:0]    ent_grade;
  logic [lpkt_pkg::KEY_W-1:0]      ent_key;

  logic                            in_fire;
  logic [lpkt_pkg::KEY_W-1:0]      rem_wide;
  logic [SLOT_W-1:0]               rem_fix;
  logic [lpkt_pkg::GRADE_W-1:0]    grade_fix;
  logic                            is_search, key_hit, at_last;
  logic                            finish, out_free, commit, hold, insert_ok, cond_true;
  logic                            best_take;

  assign ctrl       = lpkt_pkg::ucode(step_q);
  assign in_ready_o = ctrl.in_ready;
  assign in_fire    = in_valid_i & ctrl.in_ready;

  assign {ent_used, ent_grade, ent_key} = rdata;

  // The estimated quotient is exact or one too small, so one subtraction finishes the remainder.
  assign quot_d   = lpkt_pkg::KEY_W'((64'(key_q) * 64'(RECIP)) >> lpkt_pkg::KEY_W);
  assign prod_d   = quot_q * SLOTS_K;
  assign rem_wide = key_q - prod_q;
  assign rem_fix  = (rem_wide >= SLOTS_K) ? SLOT_W'(rem_wide - SLOTS_K) : SLOT_W'(rem_wide);

  assign grade_fix = (grade_i >= lpkt_pkg::GRADE_MIN && grade_i <= lpkt_pkg::GRADE_MAX)
                   ? grade_i : lpkt_pkg::GRADE_BAD;

  assign is_search = (mode_q == lpkt_pkg::MODE_SEARCH);
  assign key_hit   = ent_used & (ent_key == key_q);
  assign at_last   = (pos_q == LAST_SLOT);
  assign finish    = is_search ? (key_hit | at_last) : (~ent_used | at_last);
  assign out_free  = ~out_valid_q | out_ready_i;
  assign commit    = ctrl.eval_en & finish & out_free;
  assign hold      = ctrl.eval_en & finish & ~out_free;
  assign insert_ok = commit & ~is_search & ~ent_used;

  assign we    = ctrl.clr_en | insert_ok;
  assign wdata = ctrl.clr_en ? '0 : {1'b1, grade_q, key_q};

  lpkt_ram #(
    .WIDTH (lpkt_pkg::ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_q),
    .wdata_i (wdata),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  always_comb begin
    unique case (ctrl.cond)
      lpkt_pkg::COND_ALWAYS:   cond_true = 1'b1;
      lpkt_pkg::COND_ACCEPT:   cond_true = in_valid_i;
      lpkt_pkg::COND_CLR_LAST: cond_true = at_last;
      lpkt_pkg::COND_FINISH:   cond_true = finish;
      default:                 cond_true = 1'b1;
    endcase
  end

  assign best_take = ~any_q | (grade_q > best_grade_q)
                   | ((grade_q == best_grade_q) & (pos_q < best_idx_q));

  always_comb begin
    step_d       = hold ? step_q : (cond_true ? ctrl.on_true : ctrl.on_false);
    pos_d        = pos_q;
    any_d        = any_q;
    best_idx_d   = best_idx_q;
    best_grade_d = best_grade_q;
    best_key_d   = best_key_q;
    if (in_fire) begin
      pos_d = '0;
    end
    if (ctrl.clr_en) begin
      pos_d = at_last ? '0 : pos_q + 1'b1;
    end
    if (ctrl.mod_en) begin
      pos_d = rem_fix;
    end
    if (ctrl.eval_en & ~finish) begin
      pos_d = pos_q + 1'b1;
    end
    if (insert_ok) begin
      any_d = 1'b1;
      if (best_take) begin
        best_idx_d   = pos_q;
        best_grade_d = grade_q;
        best_key_d   = key_q;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= lpkt_pkg::STEP_CLEAR;
      pos_q        <= '0;
      any_q        <= 1'b0;
      best_idx_q   <= '0;
      best_grade_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      step_q       <= step_d;
      pos_q        <= pos_d;
      any_q        <= any_d;
      best_idx_q   <= best_idx_d;
      best_grade_q <= best_grade_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_key_q <= best_key_d;
    if (in_fire) begin
      mode_q  <= mode_i;
      key_q   <= key_i;
      grade_q <= grade_fix;
    end
    if (ctrl.quot_en) begin
      quot_q <= quot_d;
    end
    if (ctrl.prod_en) begin
      prod_q <= prod_d;
    end
    if (commit) begin
      best_valid_q     <= any_d;
      best_key_out_q   <= any_d ? best_key_d : '0;
      best_grade_out_q <= any_d ? best_grade_d : '0;
      if (is_search) begin
        status_q      <= key_hit ? lpkt_pkg::STATUS_OK : lpkt_pkg::STATUS_MISS;
        slot_q        <= key_hit ? 4'(pos_q) : '0;
        found_grade_q <= key_hit ? ent_grade : '0;
      end else begin
        status_q      <= ent_used ? lpkt_pkg::STATUS_FULL : lpkt_pkg::STATUS_OK;
        slot_q        <= ent_used ? '0 : 4'(pos_q);
        found_grade_q <= ent_used ? '0 : grade_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_o        = slot_q;
  assign found_grade_o = found_grade_q;
  assign best_valid_o  = best_valid_q;
  assign best_key_o    = best_key_out_q;
  assign best_grade_o  = best_grade_out_q;

  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == lpkt_pkg::STATUS_FULL |-> slot_o == '0 && found_grade_o == '0)
    else $error("A full-table result carries a slot or a grade.");

  a_best_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == lpkt_pkg::STATUS_OK |-> best_valid_o &&
      best_grade_o >= found_grade_o)
    else $error("The best grade is below the grade of a stored entry.");

  a_any_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |=> any_q)
    else $error("The table lost its entries without a reset.");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> step_q == lpkt_pkg::STEP_QUOT)
    else $error("An input transfer did not start the home slot computation.");

endmodule

>>> verif/tb_linear_probe_key_table.sv
// Self-checking testbench for the linear probe key table with a built-in table predictor.
module tb_linear_probe_key_table;

  localparam int unsigned TBL_SLOTS = 16;

  typedef struct packed {
    logic [1:0]                   status;
    logic [3:0]                   slot;
    logic [lpkt_pkg::GRADE_W-1:0] found_grade;
    logic                         best_valid;
    logic [lpkt_pkg::KEY_W-1:0]   best_key;
    logic [lpkt_pkg::GRADE_W-1:0] best_grade;
  } table_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         mode_i;
  logic [lpkt_pkg::KEY_W-1:0]   key_i;
  logic [lpkt_pkg::GRADE_W-1:0] grade_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [1:0]                   status_o;
  logic [3:0]                   slot_o;
  logic [lpkt_pkg::GRADE_W-1:0] found_grade_o;
  logic                         best_valid_o;
  logic [lpkt_pkg::KEY_W-1:0]   best_key_o;
  logic [lpkt_pkg::GRADE_W-1:0] best_grade_o;

  logic [lpkt_pkg::KEY_W-1:0]   tbl_key [TBL_SLOTS];
  logic [lpkt_pkg::GRADE_W-1:0] tbl_grade [TBL_SLOTS];
  logic                         tbl_used [TBL_SLOTS];
  int unsigned                  top_slot;
  logic [lpkt_pkg::GRADE_W-1:0] top_grade;
  logic                         tbl_any;

  table_result_t                pending_results[$];
  logic [lpkt_pkg::KEY_W-1:0]   stored_keys[$];
  int                           error_count = 0;
  int                           send_idle_pct = 0;
  int                           stall_pct = 0;
  int                           hold_off_left = 0;

  linear_probe_key_table #(
    .TABLE_SLOTS(TBL_SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .grade_i      (grade_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .found_grade_o(found_grade_o),
    .best_valid_o (best_valid_o),
    .best_key_o   (best_key_o),
    .best_grade_o (best_grade_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic table_result_t apply_table_op(input logic m,
                                                   input logic [lpkt_pkg::KEY_W-1:0] k,
                                                   input logic [lpkt_pkg::GRADE_W-1:0] g);
    table_result_t                r;
    int unsigned                  home;
    int unsigned                  pos;
    logic [lpkt_pkg::GRADE_W-1:0] kept;
    bit                           hit;
    r = '0;
    hit = 1'b0;
    home = k % TBL_SLOTS;
    if (m == lpkt_pkg::MODE_INSERT) begin
      kept = (g >= lpkt_pkg::GRADE_MIN && g <= lpkt_pkg::GRADE_MAX) ? g : lpkt_pkg::GRADE_BAD;
      pos = home;
      while (tbl_used[pos] && pos < TBL_SLOTS - 1) pos++;
      if (tbl_used[pos]) begin
        r.status = lpkt_pkg::STATUS_FULL;
      end else begin
        tbl_used[pos] = 1'b1;
        tbl_key[pos] = k;
        tbl_grade[pos] = kept;
        if (!tbl_any || kept > top_grade || (kept == top_grade && pos < top_slot)) begin
          top_slot = pos;
          top_grade = kept;
        end
        tbl_any = 1'b1;
        r.status = lpkt_pkg::STATUS_OK;
        r.slot = pos[3:0];
        r.found_grade = kept;
      end
    end else begin
      r.status = lpkt_pkg::STATUS_MISS;
      for (pos = home; pos < TBL_SLOTS && !hit; pos++) begin
        if (tbl_used[pos] && tbl_key[pos] == k) begin
          hit = 1'b1;
          r.status = lpkt_pkg::STATUS_OK;
          r.slot = pos[3:0];
          r.found_grade = tbl_grade[pos];
        end
      end
    end
    r.best_valid = tbl_any;
    if (tbl_any) begin
      r.best_key = tbl_key[top_slot];
      r.best_grade = top_grade;
    end
    return r;
  endfunction

  // Entered and left at a falling edge; valid is dropped after the transfer.
  task automatic send_item(input logic m, input logic [lpkt_pkg::KEY_W-1:0] k,
                           input logic [lpkt_pkg::GRADE_W-1:0] g);
    table_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      mode_i = 1'($urandom_range(1));
      key_i = $urandom;
      grade_i = lpkt_pkg::GRADE_W'($urandom_range(1023));
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    mode_i = m;
    key_i = k;
    grade_i = g;
    do @(posedge clk_i); while (!in_ready_o);
    r = apply_table_op(m, k, g);
    pending_results.push_back(r);
    if (m == lpkt_pkg::MODE_INSERT && r.status == lpkt_pkg::STATUS_OK) stored_keys.push_back(k);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_random_item();
    logic                         m;
    logic [lpkt_pkg::KEY_W-1:0]   k;
    logic [lpkt_pkg::GRADE_W-1:0] g;
    m = ($urandom_range(99) < 25) ? lpkt_pkg::MODE_INSERT : lpkt_pkg::MODE_SEARCH;
    g = ($urandom_range(99) < 60) ? lpkt_pkg::GRADE_W'($urandom_range(200, 600)) :
                                    lpkt_pkg::GRADE_W'($urandom_range(1023));
    if (m == lpkt_pkg::MODE_SEARCH && stored_keys.size() > 0 && $urandom_range(99) < 60)
      k = stored_keys[$urandom_range(stored_keys.size() - 1)];
    else if ($urandom_range(1) == 1)
      k = $urandom_range(63);
    else
      k = $urandom;
    send_item(m, k, g);
  endtask

  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string what, input logic [lpkt_pkg::KEY_W-1:0] want,
                             input logic [lpkt_pkg::KEY_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual status %0h slot %0h",
                 $time, status_o, slot_o);
      end else begin
        want = pending_results.pop_front();
        check_field("status", lpkt_pkg::KEY_W'(want.status), lpkt_pkg::KEY_W'(status_o));
        check_field("slot", lpkt_pkg::KEY_W'(want.slot), lpkt_pkg::KEY_W'(slot_o));
        check_field("found_grade", lpkt_pkg::KEY_W'(want.found_grade),
                    lpkt_pkg::KEY_W'(found_grade_o));
        check_field("best_valid", lpkt_pkg::KEY_W'(want.best_valid),
                    lpkt_pkg::KEY_W'(best_valid_o));
        check_field("best_key", want.best_key, best_key_o);
        check_field("best_grade", lpkt_pkg::KEY_W'(want.best_grade),
                    lpkt_pkg::KEY_W'(best_grade_o));
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_ready_i = 1'b0;
      hold_off_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic test_empty_table();
    send_item(lpkt_pkg::MODE_SEARCH, 32'h0000_0000, 10'd0);
    send_item(lpkt_pkg::MODE_SEARCH, 32'hFFFF_FFFF, 10'h3FF);
  endtask

  task automatic test_directed_ops();
    send_item(lpkt_pkg::MODE_INSERT, 32'd15, 10'd600);
    send_item(lpkt_pkg::MODE_INSERT, 32'd31, 10'd600);
    send_item(lpkt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 10'd300);
    send_item(lpkt_pkg::MODE_INSERT, 32'd0, 10'd0);
    send_item(lpkt_pkg::MODE_INSERT, 32'd16, 10'd1023);
    send_item(lpkt_pkg::MODE_INSERT, 32'd0, 10'd199);
    send_item(lpkt_pkg::MODE_INSERT, 32'd2, 10'd200);
    send_item(lpkt_pkg::MODE_INSERT, 32'd4, 10'd601);
    send_item(lpkt_pkg::MODE_INSERT, 32'd6, 10'd600);
    send_item(lpkt_pkg::MODE_SEARCH, 32'd0, 10'd0);
    send_item(lpkt_pkg::MODE_SEARCH, 32'd16, 10'd0);
    send_item(lpkt_pkg::MODE_SEARCH, 32'd31, 10'd0);
    send_item(lpkt_pkg::MODE_SEARCH, 32'd15, 10'd0);
    send_item(lpkt_pkg::MODE_SEARCH, 32'hFFFF_FFFF, 10'd0);
    send_item(lpkt_pkg::MODE_SEARCH, 32'd6, 10'd0);
    send_item(lpkt_pkg::MODE_SEARCH, 32'd2, 10'd0);
    send_item(lpkt_pkg::MODE_SEARCH, 32'd32, 10'd0);
    send_item(lpkt_pkg::MODE_SEARCH, 32'd5, 10'd0);
  endtask

  task automatic test_random_traffic(input int items, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (items) send_random_item();
  endtask

  // The receiver holds off long enough that the block fills and stops taking items.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off_left = 400;
    repeat (6) send_random_item();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 35;
    stall_pct = 35;
    repeat (5) send_random_item();
    wait_for_drain();
    repeat (5) send_random_item();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = lpkt_pkg::MODE_INSERT;
    key_i = '0;
    grade_i = '0;
    out_ready_i = 1'b0;
    tbl_used = '{default: 1'b0};
    tbl_key = '{default: '0};
    tbl_grade = '{default: '0};
    top_slot = 0;
    top_grade = '0;
    tbl_any = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_directed_ops();
    test_random_traffic(150, 0, 0);
    test_random_traffic(150, 68, 0);
    test_random_traffic(150, 0, 68);
    test_output_backpressure();
    test_drain_pause();
    test_random_traffic(130, 35, 35);

    wait_for_drain();
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("%0t: timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule
